// File: rtl/sdq_pkg.sv
`timescale 1ns / 1ps

package sdq_pkg;

    // Number of words the store can hold.
    localparam int DEPTH = 16;

    // Slot index, word count and slot-sum widths.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    // Fixed field widths of the items.
    localparam int REQ_W  = 3;
    localparam int WORD_W = 32;
    localparam int POS_W  = 4;
    localparam int OCC_W  = 5;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd5;

    typedef logic [AW-1:0] t_idx;
    typedef logic [CW-1:0] t_cnt;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic signed [WORD_W-1:0] value_in;
    } t_req_item;

    typedef struct packed {
        logic                     found;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] value_out;
        logic                     was_empty;
        logic                     push_rejected;
        logic [OCC_W-1:0]         occupancy;
    } t_res_item;

    // Slot that lies k places after slot a, wrapping at the store depth.
    // Valid for k below the depth.
    function automatic t_idx f_slot(input t_idx a, input t_cnt k);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(k);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return AW'(s);
    endfunction

    // Slot just before slot a, wrapping at the store depth.
    function automatic t_idx f_prev(input t_idx a);
        t_idx p;
        if (a == '0) begin
            p = AW'(DEPTH - 1);
        end else begin
            p = a - 1'b1;
        end
        return p;
    endfunction

endpackage

// File: rtl/sdq_ram.sv
`timescale 1ns / 1ps

module sdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/searchable_deque_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// --------  ---------  --------------------------  ---------------------------
// request   in         i_in_valid / o_in_stall     i_in_item  (t_req_item)
// result    out        o_out_valid / i_out_stall   o_out_item (t_res_item)
//
// Every request item yields exactly one result item. Pushes, queries and
// requests on an empty store go straight to S_DONE; pops pass through
// S_POPW for the store read, and a search walks the store in S_SRCH,
// reading and comparing one word per cycle up to the first match or the
// last word. Reset is synchronous and active low; it empties the store
// by clearing the front slot and word count, and drops a pending result.
// A stalled result stays in the output register while the next request item
// is taken and worked on; that request waits only at its last step.

module searchable_deque_core
    import sdq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_req_item i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_res_item o_out_item
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SRCH,
        S_POPW,
        S_DONE
    } t_state;

    t_state r_state;

    // Deque bookkeeping: slot of the front word and number of words held.
    t_idx r_front;
    t_cnt r_count;

    // Search sequencer: r_k and r_slot point at the next word to read,
    // r_cmp_k tags the word whose data arrives from the store this cycle.
    t_cnt r_k;
    t_idx r_slot;
    logic r_cmp_vld;
    t_cnt r_cmp_k;

    // Request word and the result being built.
    logic signed [WORD_W-1:0] r_val;
    logic                     r_found;
    logic [POS_W-1:0]         r_pos;
    logic signed [WORD_W-1:0] r_vout;
    logic                     r_empty;
    logic                     r_rej;

    // Output register.
    logic      r_out_valid;
    t_res_item r_out;

    // Store port signals.
    logic              wr_en;
    t_idx              wr_addr;
    logic [WORD_W-1:0] wr_data;
    t_idx              rd_addr;
    logic [WORD_W-1:0] rd_data;

    logic accept;
    logic is_full;
    logic is_empty;
    logic out_load;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    // The finished result moves into the output register once that register
    // is free or is being emptied in this cycle.
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Store addressing. Pushes write in the cycle the item is taken; pops
    // read there too, and the search walks the read port from r_slot.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = f_slot(r_front, r_count);
        wr_data = i_in_item.value_in;
        rd_addr = r_slot;
        if (accept) begin
            case (i_in_item.req_type)
                REQ_PUSH_FRONT: begin
                    wr_en   = !is_full;
                    wr_addr = f_prev(r_front);
                end
                REQ_PUSH_BACK: begin
                    wr_en   = !is_full;
                    wr_addr = f_slot(r_front, r_count);
                end
                REQ_POP_FRONT: begin
                    rd_addr = r_front;
                end
                REQ_POP_BACK: begin
                    rd_addr = f_slot(r_front, r_count - 1'b1);
                end
                default: begin
                    rd_addr = r_slot;
                end
            endcase
        end
    end

    sdq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_val     <= i_in_item.value_in;
                        r_found   <= 1'b0;
                        r_pos     <= '0;
                        r_vout    <= '0;
                        r_empty   <= is_empty;
                        r_rej     <= (i_in_item.req_type inside
                                      {REQ_PUSH_FRONT, REQ_PUSH_BACK}) && is_full;
                        r_k       <= '0;
                        r_slot    <= r_front;
                        r_cmp_vld <= 1'b0;
                        // Searches and pops on a nonempty store need the
                        // store read port; everything else is finished.
                        if ((i_in_item.req_type == REQ_SEARCH) && !is_empty) begin
                            r_state <= S_SRCH;
                        end else if ((i_in_item.req_type inside
                                      {REQ_POP_FRONT, REQ_POP_BACK}) && !is_empty) begin
                            r_state <= S_POPW;
                        end else begin
                            r_state <= S_DONE;
                        end
                        case (i_in_item.req_type)
                            REQ_PUSH_FRONT: begin
                                if (!is_full) begin
                                    r_front <= f_prev(r_front);
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            REQ_PUSH_BACK: begin
                                if (!is_full) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            REQ_POP_FRONT: begin
                                if (!is_empty) begin
                                    r_front <= f_slot(r_front, CW'(1));
                                    r_count <= r_count - 1'b1;
                                end
                            end
                            REQ_POP_BACK: begin
                                if (!is_empty) begin
                                    r_count <= r_count - 1'b1;
                                end
                            end
                            default: begin
                                // Searches, queries and unused codes leave the
                                // front slot and word count alone.
                            end
                        endcase
                    end
                end

                S_SRCH: begin
                    // Issue the next read while comparing the previous word.
                    if (r_k != r_count) begin
                        r_k       <= r_k + 1'b1;
                        r_slot    <= f_slot(r_slot, CW'(1));
                        r_cmp_vld <= 1'b1;
                        r_cmp_k   <= r_k;
                    end else begin
                        r_cmp_vld <= 1'b0;
                    end
                    if (r_cmp_vld) begin
                        if (rd_data == r_val) begin
                            r_found <= 1'b1;
                            r_pos   <= POS_W'(r_cmp_k);
                            r_state <= S_DONE;
                        end else if (r_cmp_k == r_count - 1'b1) begin
                            r_state <= S_DONE;
                        end
                    end
                end

                S_POPW: begin
                    r_vout  <= rd_data;
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    if (out_load) begin
                        r_out.found         <= r_found;
                        r_out.position      <= r_pos;
                        r_out.value_out     <= r_vout;
                        r_out.was_empty     <= r_empty;
                        r_out.push_rejected <= r_rej;
                        r_out.occupancy     <= OCC_W'(r_count);
                        r_state             <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/sdq_checker.sv
`timescale 1ns / 1ps

module sdq_checker
    import sdq_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_req_item i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_res_item o_out_item
);

    // A held result item keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    // The block works on one request item at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request item taken while another is in progress");

    // A refused push only happens on a full store.
    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.push_rejected |-> o_out_item.occupancy == OCC_W'(DEPTH))
        else $error("push refused below full occupancy");

    // A match or a popped nonzero word needs a store that held words.
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.found || o_out_item.value_out != '0)
        |-> !o_out_item.was_empty)
        else $error("data reported from an empty store");

    // A search result and a push refusal never come together.
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.found && o_out_item.push_rejected))
        else $error("found and push_rejected both set");

endmodule

bind searchable_deque_core sdq_checker u_sdq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

// File: bench/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for searchable_deque_core.
//
// The bench runs a small copy of the deque of its own (held_words, head_slot
// and held_count). Every request item that the core accepts is applied to that
// copy at once. The result that the copy gives is queued in awaited_results.
// Each result item that leaves the core is checked against the oldest entry
// in that queue, one field at a time.
//
// Stimulus comes in two parts.
//   1. A short directed plan. It covers the empty store, spare request codes,
//      the extreme words, filling the store to the brim, refused pushes, and
//      a search that hits the last slot. Where the answer is plain at a
//      glance, it is typed into the plan. Other rows use the bench's own copy.
//   2. Random traffic that swings between filling and draining the store.
//      The full and empty edges are therefore hit many times, and the buffer
//      wraps in both directions. Search words are mostly taken from live
//      entries, and pushed words often repeat, so first-match ordering is
//      exercised.
//
// Handshake pressure changes in three phases. First the sender idles rarely
// while the receiver stalls most of the time. Then the two swap. Last,
// nobody idles.

module testbench;
    import sdq_pkg::*;

    // Request codes that the core treats like a query.
    localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

    localparam int TOTAL_ITEMS = 1050;
    localparam int PHASE_ITEMS = 350;
    localparam int MAX_REPORTS = 10;
    localparam int TAIL_CYCLES = 4 * (DEPTH + 3);
    localparam int CYCLE_LIMIT = 400000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_req_item in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_res_item out_item;

    searchable_deque_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Bench copy of the deque state.
    logic signed [WORD_W-1:0] held_words [DEPTH];
    int head_slot = 0;
    int held_count = 0;

    t_res_item awaited_results [$];

    // Handshake pressure in percent, changed per phase by the sender.
    int send_idle_pct = 15;
    int recv_stall_pct = 83;

    int mismatches = 0;
    int cycles = 0;
    int items_sent = 0;

    // Totals for the closing summary.
    int req_seen [8];
    int search_hits = 0;
    int pushes_refused = 0;
    int pops_on_empty = 0;
    int times_full = 0;

    // While this is set, the random traffic favors pushes. When it is clear,
    // it favors pops.
    bit filling = 1'b1;

    // One row of the directed plan. A row with reps above one sends the same
    // request several times, stepping the word by one on each send.
    typedef struct {
        logic [REQ_W-1:0]         code;
        logic signed [WORD_W-1:0] word;
        int                       reps;
        bit                       typed;
        t_res_item                want;
    } t_plan_row;

    t_plan_row plan [$];

    function automatic t_res_item mk_result(input bit found, input int pos,
                                            input logic signed [WORD_W-1:0] word,
                                            input bit empty, input bit refused,
                                            input int occ);
        t_res_item r;
        r.found         = found;
        r.position      = POS_W'(pos);
        r.value_out     = word;
        r.was_empty     = empty;
        r.push_rejected = refused;
        r.occupancy     = OCC_W'(occ);
        return r;
    endfunction

    function automatic void plan_add(input logic [REQ_W-1:0] code,
                                     input logic signed [WORD_W-1:0] word,
                                     input int reps, input bit typed,
                                     input t_res_item want);
        t_plan_row row;
        row.code  = code;
        row.word  = word;
        row.reps  = reps;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endfunction

    // Applies one request to the bench copy and returns the result that the
    // core must give for it.
    function automatic t_res_item deque_apply(input t_req_item req);
        t_res_item res;
        int k;
        res = '0;
        res.was_empty = (held_count == 0);
        case (req.req_type)
            REQ_SEARCH: begin
                // Scan from the front. Only the first match counts.
                for (k = 0; k < held_count; k++) begin
                    if (!res.found &&
                        held_words[(head_slot + k) % DEPTH] == req.value_in) begin
                        res.found    = 1'b1;
                        res.position = POS_W'(k);
                    end
                end
            end
            REQ_PUSH_FRONT: begin
                if (held_count >= DEPTH) begin
                    res.push_rejected = 1'b1;
                end else begin
                    head_slot = (head_slot + DEPTH - 1) % DEPTH;
                    held_words[head_slot] = req.value_in;
                    held_count++;
                end
            end
            REQ_PUSH_BACK: begin
                if (held_count >= DEPTH) begin
                    res.push_rejected = 1'b1;
                end else begin
                    held_words[(head_slot + held_count) % DEPTH] = req.value_in;
                    held_count++;
                end
            end
            REQ_POP_FRONT: begin
                if (held_count != 0) begin
                    res.value_out = held_words[head_slot];
                    head_slot = (head_slot + 1) % DEPTH;
                    held_count--;
                end
            end
            REQ_POP_BACK: begin
                if (held_count != 0) begin
                    res.value_out = held_words[(head_slot + held_count - 1) % DEPTH];
                    held_count--;
                end
            end
            default: begin
                // A query or a spare code leaves the store as it is.
            end
        endcase
        res.occupancy = OCC_W'(held_count);
        return res;
    endfunction

    // Picks a word to push. Many pushes draw from a small pool so that a
    // search has duplicates to choose between. Others are the extreme words or random.
    function automatic logic signed [WORD_W-1:0] pick_word();
        logic signed [WORD_W-1:0] w;
        case ($urandom_range(0, 3))
            0: w = $urandom_range(0, 7);
            1: begin
                case ($urandom_range(0, 3))
                    0: w = 32'sh8000_0000;
                    1: w = 32'sh7FFF_FFFF;
                    2: w = '1;
                    default: w = '0;
                endcase
            end
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // Builds the next random request. The choice depends on the bench copy,
    // so the traffic keeps moving between the full and the empty store.
    function automatic t_req_item pick_request();
        t_req_item req;
        int roll;
        bit grow;
        if (held_count == DEPTH) begin
            filling = 1'b0;
        end else if (held_count == 0) begin
            filling = 1'b1;
        end else if ($urandom_range(0, 99) < 3) begin
            filling = !filling;
        end
        roll = $urandom_range(0, 99);
        req.value_in = pick_word();
        if (roll < 30) begin
            req.req_type = REQ_SEARCH;
            // Most searches target a live word. The rest are likely misses.
            if (held_count > 0 && $urandom_range(0, 3) != 0) begin
                req.value_in =
                    held_words[(head_slot + $urandom_range(0, held_count - 1)) % DEPTH];
            end
        end else if (roll < 92) begin
            grow = (roll < 77) ? filling : !filling;
            if (grow) begin
                req.req_type = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
            end else begin
                req.req_type = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
            end
        end else if (roll < 97) begin
            req.req_type = REQ_QUERY;
        end else begin
            req.req_type = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
        end
        return req;
    endfunction

    // Presents one request item and holds it until the core takes it. The
    // expected result is queued as the item is accepted. A typed expectation
    // takes the place of the predicted one, but the bench copy is still
    // updated.
    task automatic send_request(input t_req_item req, input bit typed,
                                input t_res_item want);
        t_res_item predicted;
        if (items_sent < PHASE_ITEMS) begin
            send_idle_pct  = 15;
            recv_stall_pct = 83;
        end else if (items_sent < 2 * PHASE_ITEMS) begin
            send_idle_pct  = 83;
            recv_stall_pct = 15;
        end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = req;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        predicted = deque_apply(req);
        awaited_results.push_back(typed ? want : predicted);
        items_sent++;
        req_seen[req.req_type]++;
        if (predicted.found) begin
            search_hits++;
        end
        if (predicted.push_rejected) begin
            pushes_refused++;
        end
        if ((req.req_type == REQ_POP_FRONT || req.req_type == REQ_POP_BACK) &&
            predicted.was_empty) begin
            pops_on_empty++;
        end
        if ((req.req_type == REQ_PUSH_FRONT || req.req_type == REQ_PUSH_BACK) &&
            !predicted.push_rejected && held_count == DEPTH) begin
            times_full++;
        end
        @(negedge clk);
    endtask

    // The receiver stalls at random, with the rate set by the current phase.
    always @(negedge clk) begin
        out_stall = ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Check every result item that the core delivers.
    always @(posedge clk) begin
        t_res_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("[%0t] result with none awaited: %p", $realtime, out_item);
                end
            end else begin
                want = awaited_results.pop_front();
                if (out_item.found !== want.found ||
                    out_item.position !== want.position ||
                    out_item.value_out !== want.value_out ||
                    out_item.was_empty !== want.was_empty ||
                    out_item.push_rejected !== want.push_rejected ||
                    out_item.occupancy !== want.occupancy) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("[%0t] mismatch: expected %p", $realtime, want);
                        $display("[%0t]           actual   %p", $realtime, out_item);
                    end
                end
            end
        end
    end

    // A run that hangs is a failure.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, awaited_results.size());
            $display("** searchable_deque_core: FAILED **");
            $finish;
        end
    end

    initial begin
        t_req_item req;
        foreach (held_words[k]) begin
            held_words[k] = '0;
        end
        foreach (req_seen[k]) begin
            req_seen[k] = 0;
        end

        // The store starts empty. Each request in this group reports was_empty
        // and leaves zero words. The spare codes must answer like a query.
        plan_add(REQ_QUERY,      '0, 1, 1'b1, mk_result(0, 0, '0, 1, 0, 0));
        plan_add(REQ_POP_FRONT,  '0, 1, 1'b1, mk_result(0, 0, '0, 1, 0, 0));
        plan_add(REQ_POP_BACK,   '0, 1, 1'b1, mk_result(0, 0, '0, 1, 0, 0));
        plan_add(REQ_SEARCH,     '0, 1, 1'b1, mk_result(0, 0, '0, 1, 0, 0));
        plan_add(REQ_SPARE_A,    '1, 1, 1'b1, mk_result(0, 0, '0, 1, 0, 0));
        plan_add(REQ_SPARE_B,    '1, 1, 1'b1, mk_result(0, 0, '0, 1, 0, 0));
        // Extreme words at both ends. The front push wraps the head slot below
        // zero. Both words must then be found at their offsets.
        plan_add(REQ_PUSH_BACK,  32'sh7FFF_FFFF, 1, 1'b1, mk_result(0, 0, '0, 1, 0, 1));
        plan_add(REQ_PUSH_FRONT, 32'sh8000_0000, 1, 1'b1, mk_result(0, 0, '0, 0, 0, 2));
        plan_add(REQ_SEARCH,     32'sh8000_0000, 1, 1'b1, mk_result(1, 0, '0, 0, 0, 2));
        plan_add(REQ_SEARCH,     32'sh7FFF_FFFF, 1, 1'b1, mk_result(1, 1, '0, 0, 0, 2));
        // Fill to the brim from both ends, with alternating bit patterns.
        plan_add(REQ_PUSH_BACK,  32'sh5555_5555, 7, 1'b0, '0);
        plan_add(REQ_PUSH_FRONT, 32'shAAAA_AAAA, 7, 1'b0, '0);
        // A full store refuses a push at either end.
        plan_add(REQ_PUSH_FRONT, '0, 1, 1'b1, mk_result(0, 0, '0, 0, 1, DEPTH));
        plan_add(REQ_PUSH_BACK,  '1, 1, 1'b1, mk_result(0, 0, '0, 0, 1, DEPTH));
        // The last word sits at the deepest position.
        plan_add(REQ_SEARCH,     32'sh5555_555B, 1, 1'b0, '0);
        plan_add(REQ_POP_BACK,   '0, 1, 1'b0, '0);
        plan_add(REQ_POP_FRONT,  '0, 1, 1'b0, '0);

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[k]) begin
            for (int r = 0; r < plan[k].reps; r++) begin
                req.req_type = plan[k].code;
                req.value_in = plan[k].word + r;
                send_request(req, plan[k].typed, plan[k].want);
            end
        end

        while (items_sent < TOTAL_ITEMS) begin
            req = pick_request();
            send_request(req, 1'b0, '0);
        end
        in_valid = 1'b0;

        // Drain. Then allow for the longest search to settle before judging.
        while (awaited_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d requests in %0d cycles: %0d searches (%0d hits), %0d pushes",
                 items_sent, cycles, req_seen[REQ_SEARCH], search_hits,
                 req_seen[REQ_PUSH_FRONT] + req_seen[REQ_PUSH_BACK]);
        $display("  (%0d refused, full %0d times), %0d pops (%0d on empty), %0d mismatches",
                 pushes_refused, times_full,
                 req_seen[REQ_POP_FRONT] + req_seen[REQ_POP_BACK], pops_on_empty,
                 mismatches);
        if (mismatches == 0) begin
            $display("** searchable_deque_core: PASSED **");
        end else begin
            $display("** searchable_deque_core: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/sdq_pkg.sv
rtl/sdq_ram.sv
rtl/searchable_deque_core.sv
rtl/sdq_checker.sv
bench/testbench.sv
